### rtl/core/ple_pkg.sv
package ple_pkg;

  // List capacity and derived widths
  localparam int DEPTH       = 16;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int MAX_RESULTS = 16;
  localparam int RD_W        = (CNT_W > 5) ? CNT_W : 5;

  // Fixed field widths
  localparam int VAL_W   = 32;
  localparam int POS_W   = 8;
  localparam int ITEM_W  = 4;
  localparam int ENTRY_W = 5;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_END   = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_END   = 3'd4,
    OP_DEL_POS   = 3'd5,
    OP_READ      = 3'd6,
    OP_NOP       = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_INS,
    CM_DEL,
    CM_ROT
  } cell_mode_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  typedef struct packed {
    op_t                      op;
    logic signed [VAL_W-1:0]  value;
    logic [POS_W-1:0]         position;
  } in_word_t;

  typedef struct packed {
    status_t                  status;
    logic signed [VAL_W-1:0]  item_value;
    logic [ITEM_W-1:0]        item_index;
    logic [ENTRY_W-1:0]       entry_count;
    logic                     last;
  } out_word_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    cell_mode_t               mode;
    logic [POS_W-1:0]         pos;
    logic [IDX_W-1:0]         last_idx;
    logic signed [VAL_W-1:0]  value;
  } cell_ctrl_t;

endpackage

### rtl/core/ple_cell.sv
module ple_cell
  import ple_pkg::*;
(
  input  logic                     clk,
  input  cell_ctrl_t               ctrl,
  input  logic [IDX_W-1:0]         my_idx,
  input  logic signed [VAL_W-1:0]  left_val,
  input  logic signed [VAL_W-1:0]  right_val,
  input  logic signed [VAL_W-1:0]  head_val,
  output logic signed [VAL_W-1:0]  val_out
);

  logic signed [VAL_W-1:0] val_r;
  logic signed [VAL_W-1:0] val_nxt;
  logic [POS_W-1:0]        idx_ext;

  assign idx_ext = POS_W'(my_idx);

  // Insert opens a gap at pos, delete closes it, rotate walks the list past cell 0
  always_comb begin
    val_nxt = val_r;
    case (ctrl.mode)
      CM_INS: begin
        if (idx_ext > ctrl.pos) begin
          val_nxt = left_val;
        end else if (idx_ext == ctrl.pos) begin
          val_nxt = ctrl.value;
        end
      end
      CM_DEL: begin
        if (idx_ext >= ctrl.pos) begin
          val_nxt = right_val;
        end
      end
      CM_ROT: begin
        if (my_idx == ctrl.last_idx) begin
          val_nxt = head_val;
        end else begin
          val_nxt = right_val;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val_out = val_r;

endmodule

### rtl/core/positional_list_engine.sv
// Updates (insert/delete/no-op): result strobes the cycle after acceptance; busy stays low,
// so a new word can be accepted every cycle.
// Read-out: busy while the chain rotates once per element, one cell per cycle; first element
// crosses read state and result register, then one per cycle; empty reads answer next cycle.
// Synchronous active-low reset empties the list; the receiver cannot stall results.
module positional_list_engine
  import ple_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [RD_W-1:0]  rd_k_r, rd_k_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r, out_word_nxt;
  cell_ctrl_t       ctrl;

  logic signed [VAL_W-1:0] cell_val [DEPTH];

  logic             accept;
  logic [POS_W-1:0] count_ext;
  logic [RD_W-1:0]  rd_limit;
  logic [RD_W-1:0]  rd_final;

  assign accept    = start && (state_r == S_IDLE);
  assign count_ext = POS_W'(count_r);
  assign rd_limit  = (RD_W'(count_r) < RD_W'(MAX_RESULTS)) ? RD_W'(count_r)
                                                           : RD_W'(MAX_RESULTS);
  assign rd_final  = RD_W'(count_r - 1'b1);

  // Chain of cells, cell 0 is the front
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_w;
    logic signed [VAL_W-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = ctrl.value;
    end else begin : g_mid_l
      assign left_w = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = cell_val[i];
    end else begin : g_mid_r
      assign right_w = cell_val[i+1];
    end
    ple_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .my_idx    (IDX_W'(i)),
      .left_val  (left_w),
      .right_val (right_w),
      .head_val  (cell_val[0]),
      .val_out   (cell_val[i])
    );
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_word.op == OP_READ) && (count_r != '0)) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (rd_k_r == rd_final) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Operation decode, chain control and result word
  always_comb begin
    logic [POS_W-1:0] eff_pos;
    ctrl.mode     = CM_HOLD;
    ctrl.pos      = '0;
    ctrl.last_idx = IDX_W'(count_r - 1'b1);
    ctrl.value    = in_word.value;
    count_nxt     = count_r;
    rd_k_nxt      = rd_k_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = '0;
    eff_pos       = in_word.position;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt    = 1'b1;
          out_word_nxt.last = 1'b1;
          out_word_nxt.status = ST_OK;
          case (in_word.op)
            OP_INS_FRONT, OP_INS_END, OP_INS_POS: begin
              if (in_word.op == OP_INS_FRONT) begin
                eff_pos = '0;
              end else if (in_word.op == OP_INS_END) begin
                eff_pos = count_ext;
              end
              if (count_r == CNT_W'(DEPTH)) begin
                out_word_nxt.status = ST_FULL;
              end else if (eff_pos > count_ext) begin
                out_word_nxt.status = ST_RANGE;
              end else begin
                ctrl.mode = CM_INS;
                ctrl.pos  = eff_pos;
                count_nxt = CNT_W'(count_r + 1'b1);
              end
            end
            OP_DEL_FRONT, OP_DEL_END, OP_DEL_POS: begin
              if (in_word.op == OP_DEL_FRONT) begin
                eff_pos = '0;
              end else if (in_word.op == OP_DEL_END) begin
                eff_pos = POS_W'(count_r - 1'b1);
              end
              if (count_r == '0) begin
                out_word_nxt.status = ST_EMPTY;
              end else if (eff_pos >= count_ext) begin
                out_word_nxt.status = ST_RANGE;
              end else begin
                ctrl.mode = CM_DEL;
                ctrl.pos  = eff_pos;
                count_nxt = CNT_W'(count_r - 1'b1);
              end
            end
            OP_READ: begin
              if (count_r == '0) begin
                out_word_nxt.status = ST_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                rd_k_nxt      = '0;
              end
            end
            default: out_word_nxt.status = ST_OK;
          endcase
          out_word_nxt.entry_count = ENTRY_W'(count_nxt);
        end
      end
      S_READ: begin
        // Cell 0 holds element rd_k after rd_k rotations; count rotations restore order
        ctrl.mode = CM_ROT;
        rd_k_nxt  = RD_W'(rd_k_r + 1'b1);
        if (rd_k_r < RD_W'(MAX_RESULTS)) begin
          out_valid_nxt            = 1'b1;
          out_word_nxt.status      = ST_OK;
          out_word_nxt.item_value  = cell_val[0];
          out_word_nxt.item_index  = rd_k_r[ITEM_W-1:0];
          out_word_nxt.entry_count = ENTRY_W'(count_r);
          out_word_nxt.last        = (RD_W'(rd_k_r + 1'b1) == rd_limit);
        end
      end
      default: ctrl.mode = CM_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_k_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_k_r      <= rd_k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result word payload
  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign busy      = (state_r == S_READ);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

### rtl/core/ple_checker.sv
module ple_checker
  import ple_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_word_t  in_word,
  input logic      out_valid,
  input out_word_t out_word
);

  // Every non-read word answers with one final result in the next cycle
  a_update_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_word.op != OP_READ)) |=> (out_valid && out_word.last))
    else $error("update word did not answer next cycle");

  // Read-out results come back to back until the last one
  a_read_contig: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.last) |=> out_valid)
    else $error("gap inside read-out");

  // Error statuses end the request
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_word.status != ST_OK)) |-> out_word.last)
    else $error("error status without last");

  // An empty report carries a zero count and no data
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_word.status == ST_EMPTY))
      |-> ((out_word.item_value == '0) && (out_word.entry_count == '0)))
    else $error("empty report carries data");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_word  (out_word)
);

### sim/list_result_checker.sv
// Watches the request and result channels of positional_list_engine, keeps its own
// copy of the list, and checks every result word in order against the prediction.
module list_result_checker
  import ple_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_word_t  in_word,
  input  logic      out_valid,
  input  out_word_t out_word,
  input  logic      end_of_run,
  output int        errors,
  output int        pending,
  output int        requests,
  output int        words,
  output int        full_hits,
  output int        range_hits,
  output int        empty_hits
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow list, front at index 0
  logic [VAL_W-1:0] list_vals [DEPTH];
  int               list_len = 0;

  // Result words still owed by the block, oldest first
  out_word_t        expected_words [$];

  int err_cnt      = 0;
  int req_cnt      = 0;
  int word_cnt     = 0;
  int full_cnt     = 0;
  int range_cnt    = 0;
  int empty_cnt    = 0;
  bit leftover_hit = 1'b0;

  assign errors     = err_cnt;
  assign requests   = req_cnt;
  assign words      = word_cnt;
  assign full_hits  = full_cnt;
  assign range_hits = range_cnt;
  assign empty_hits = empty_cnt;

  task automatic report_mismatch(input string msg);
    err_cnt++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Full is checked before the position
  function automatic status_t insert_cell(input int pos, input logic [VAL_W-1:0] v);
    int i;
    if (list_len >= DEPTH) return ST_FULL;
    if (pos > list_len) return ST_RANGE;
    for (i = list_len; i > pos; i--) list_vals[i] = list_vals[i-1];
    list_vals[pos] = v;
    list_len++;
    return ST_OK;
  endfunction

  // Empty is checked before the position
  function automatic status_t remove_cell(input int pos);
    int i;
    if (list_len == 0) return ST_EMPTY;
    if (pos >= list_len) return ST_RANGE;
    for (i = pos; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
    list_len--;
    return ST_OK;
  endfunction

  // Apply one accepted request to the shadow list and queue the words it causes
  task automatic apply_request(input in_word_t w);
    out_word_t r;
    int        n;
    r      = '0;
    r.last = 1'b1;
    if (w.op == OP_READ && list_len != 0) begin
      n = (list_len < MAX_RESULTS) ? list_len : MAX_RESULTS;
      for (int k = 0; k < n; k++) begin
        r.status      = ST_OK;
        r.item_value  = list_vals[k];
        r.item_index  = ITEM_W'(k);
        r.entry_count = ENTRY_W'(list_len);
        r.last        = (k + 1 == n);
        expected_words.push_back(r);
      end
    end else begin
      case (w.op)
        OP_INS_FRONT: r.status = insert_cell(0, w.value);
        OP_INS_END:   r.status = insert_cell(list_len, w.value);
        OP_INS_POS:   r.status = insert_cell(int'(w.position), w.value);
        OP_DEL_FRONT: r.status = remove_cell(0);
        OP_DEL_END:   r.status = (list_len == 0) ? ST_EMPTY : remove_cell(list_len - 1);
        OP_DEL_POS:   r.status = remove_cell(int'(w.position));
        OP_READ:      r.status = ST_EMPTY;
        default:      r.status = ST_OK;
      endcase
      r.entry_count = ENTRY_W'(list_len);
      expected_words.push_back(r);
    end
  endtask

  // Results first: a word at this edge always belongs to an older request
  always @(posedge clk) begin : watch_channels
    out_word_t exp_w;
    if (!rst_n) begin
      list_len = 0;
      expected_words.delete();
    end else begin
      if ($isunknown({busy, out_valid}))
        report_mismatch($sformatf("busy/out_valid unknown (%b%b)", busy, out_valid));
      if (out_valid === 1'b1) begin
        word_cnt++;
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected result word %h", out_word));
        end else begin
          exp_w = expected_words.pop_front();
          case (exp_w.status)
            ST_FULL:  full_cnt++;
            ST_RANGE: range_cnt++;
            ST_EMPTY: empty_cnt++;
            default:  ;
          endcase
          if (out_word.status !== exp_w.status)
            report_mismatch($sformatf("status got %0d exp %0d",
                                      out_word.status, exp_w.status));
          if (out_word.item_value !== exp_w.item_value)
            report_mismatch($sformatf("item_value got %h exp %h",
                                      out_word.item_value, exp_w.item_value));
          if (out_word.item_index !== exp_w.item_index)
            report_mismatch($sformatf("item_index got %0d exp %0d",
                                      out_word.item_index, exp_w.item_index));
          if (out_word.entry_count !== exp_w.entry_count)
            report_mismatch($sformatf("entry_count got %0d exp %0d",
                                      out_word.entry_count, exp_w.entry_count));
          if (out_word.last !== exp_w.last)
            report_mismatch($sformatf("last got %b exp %b", out_word.last, exp_w.last));
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        req_cnt++;
        apply_request(in_word);
      end
      if (end_of_run && !leftover_hit && expected_words.size() != 0) begin
        leftover_hit = 1'b1;
        report_mismatch($sformatf("%0d result words never arrived", expected_words.size()));
      end
    end
    pending <= expected_words.size();
  end

endmodule

### sim/tb_positional_list_engine.sv
// Stimulus and verdict for positional_list_engine; checking lives in list_result_checker.
module tb_positional_list_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import ple_pkg::*;

  localparam int RAND_ITEMS  = 300;
  localparam int CALM_FROM   = 240;     // no hold-offs past this many random words
  localparam int CYCLE_LIMIT = 200000;

  logic      clk        = 1'b0;
  logic      rst_n      = 1'b0;
  logic      start      = 1'b0;
  in_word_t  in_word    = '0;
  logic      end_of_run = 1'b0;
  logic      busy;
  logic      out_valid;
  out_word_t out_word;

  int errors, pending, requests, words, full_hits, range_hits, empty_hits;

  int fill_level = 0;   // list length as seen by the stimulus, for shaping only
  int rand_sent  = 0;
  bit calm       = 1'b0;
  int cycle_cnt  = 0;

  positional_list_engine DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  list_result_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .end_of_run(end_of_run),
    .errors    (errors),
    .pending   (pending),
    .requests  (requests),
    .words     (words),
    .full_hits (full_hits),
    .range_hits(range_hits),
    .empty_hits(empty_hits)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard stop
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words still owed", cycle_cnt, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Drive one request word and hold it until the block takes it
  task automatic send_word(input op_t op, input logic [VAL_W-1:0] val,
                           input logic [POS_W-1:0] pos);
    in_word_t w;
    int       p;
    w.op       = op;
    w.value    = val;
    w.position = pos;
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy !== 1'b0);
    // track the length so later words can aim at valid positions
    case (op)
      OP_INS_FRONT, OP_INS_END, OP_INS_POS: begin
        p = (op == OP_INS_FRONT) ? 0 : (op == OP_INS_END) ? fill_level : int'(pos);
        if (fill_level < DEPTH && p <= fill_level) fill_level++;
      end
      OP_DEL_FRONT, OP_DEL_END, OP_DEL_POS: begin
        p = (op == OP_DEL_FRONT) ? 0 : (op == OP_DEL_END) ? fill_level - 1 : int'(pos);
        if (fill_level > 0 && p >= 0 && p < fill_level) fill_level--;
      end
      default: ;
    endcase
  endtask

  task automatic hold_off(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Sender pauses until the block has answered everything
  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Random word with an occasional hold-off burst in front of it
  task automatic issue(input op_t op, input logic [VAL_W-1:0] val,
                       input logic [POS_W-1:0] pos);
    if (!calm && $urandom_range(0, 2) == 0) hold_off($urandom_range(1, 10));
    send_word(op, val, pos);
    rand_sent++;
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Mostly positions around the current length, sometimes anywhere
  function automatic logic [POS_W-1:0] pick_position();
    if ($urandom_range(0, 3) == 0) return POS_W'($urandom_range(0, 255));
    return POS_W'($urandom_range(0, fill_level + 1));
  endfunction

  initial begin : stimulus
    int phase;
    int kind;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty cases, value extremes, position bounds, no-op
    send_word(OP_READ,      32'h0,         8'd0);
    send_word(OP_DEL_FRONT, 32'h0,         8'd0);
    send_word(OP_DEL_END,   32'h0,         8'd0);
    send_word(OP_DEL_POS,   32'h0,         8'd255);   // empty wins over range
    send_word(OP_INS_FRONT, 32'h8000_0000, 8'd0);
    send_word(OP_INS_END,   32'h7fff_ffff, 8'd255);
    send_word(OP_INS_POS,   32'h0,         8'd1);
    send_word(OP_INS_POS,   32'h1234_5678, 8'd4);     // above count
    send_word(OP_INS_POS,   32'hffff_ffff, 8'd3);     // equal to count: append
    send_word(OP_INS_POS,   32'h5555_aaaa, 8'd255);
    send_word(OP_NOP,       32'hdead_beef, 8'haa);
    send_word(OP_READ,      32'h0,         8'd0);
    send_word(OP_DEL_POS,   32'h0,         8'd4);     // equal to count
    send_word(OP_DEL_POS,   32'h0,         8'd255);
    send_word(OP_DEL_POS,   32'h0,         8'd1);
    send_word(OP_DEL_END,   32'h0,         8'd0);
    send_word(OP_DEL_FRONT, 32'h0,         8'd0);
    send_word(OP_READ,      32'h0,         8'd0);
    send_word(OP_DEL_POS,   32'h0,         8'd0);
    send_word(OP_NOP,       32'h0,         8'd0);
    wait_for_results();

    // Random: fill to full, drain to empty, and mixed traffic
    phase = 0;
    while (rand_sent < RAND_ITEMS) begin
      calm = (rand_sent >= CALM_FROM) || ($urandom_range(0, 2) == 0);
      if (phase > 0 && rand_sent < CALM_FROM && $urandom_range(0, 5) == 0)
        wait_for_results();
      kind = (phase < 2) ? phase : $urandom_range(0, 3);
      case (kind)
        0: begin
          while (fill_level < DEPTH)
            issue(op_t'($urandom_range(0, 2)), pick_value(),
                  POS_W'($urandom_range(0, fill_level)));
          // full takes precedence over any position
          repeat ($urandom_range(1, 3))
            issue(op_t'($urandom_range(0, 2)), pick_value(), POS_W'($urandom_range(0, 255)));
          issue(OP_READ, pick_value(), pick_position());
        end
        1: begin
          while (fill_level > 0)
            issue(op_t'($urandom_range(3, 5)), pick_value(),
                  POS_W'($urandom_range(0, fill_level - 1)));
          repeat ($urandom_range(1, 2))
            issue(op_t'($urandom_range(3, 5)), pick_value(), POS_W'($urandom_range(0, 255)));
          issue(OP_READ, pick_value(), pick_position());
        end
        default: begin
          repeat ($urandom_range(8, 25))
            issue(op_t'($urandom_range(0, 7)), pick_value(), pick_position());
        end
      endcase
      phase++;
    end

    // Drain, let any stray word show up, then flag what never came
    wait_for_results();
    repeat (4) @(posedge clk);
    end_of_run <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Covered %0d requests and %0d result words, list filled and drained repeatedly",
             requests, words);
    $display("Status hits: full %0d, out of range %0d, empty %0d; mismatches %0d",
             full_hits, range_hits, empty_hits, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
